// ===== rtl/lzs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_pkg
// Shared types and constants of the LZS stream decompressor: token decode
// phases, decode events, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lzs_pkg;

  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 11;
  localparam int CNT_W   = 4;
  localparam int RUN_W   = 5;
  localparam int OFF_W   = 11;

  // bits per input word
  localparam logic [CNT_W-1:0] BYTE_BITS  = 4'd8;

  // field sizes of the token grammar
  localparam logic [CNT_W-1:0] LIT_BITS   = 4'd8;
  localparam logic [CNT_W-1:0] OFF7_BITS  = 4'd7;
  localparam logic [CNT_W-1:0] OFF11_BITS = 4'd11;
  localparam logic [CNT_W-1:0] LEN_BITS   = 4'd2;
  localparam logic [CNT_W-1:0] NIB_BITS   = 4'd4;

  // length code escapes and bases
  localparam logic [1:0]       LEN_ESC    = 2'b11;
  localparam logic [3:0]       NIB_ESC    = 4'hF;
  localparam logic [RUN_W-1:0] LEN1_BASE  = 5'd2;
  localparam logic [RUN_W-1:0] LEN2_BASE  = 5'd5;
  localparam logic [RUN_W-1:0] NIB_BASE   = 5'd8;
  localparam logic [RUN_W-1:0] NIB_RUN    = 5'd15;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_KIND,
    PH_LIT,
    PH_OFF7,
    PH_OFF11,
    PH_LEN1,
    PH_LEN2,
    PH_NIBBLE
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_LIT,
    EV_END,
    EV_RUN
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIT,
    ST_READ,
    ST_WRITE,
    ST_FLUSH
  } ctl_state_t;

  typedef struct packed {
    logic load;     // take a new input word
    logic step;     // decode one bit
    logic rd;       // issue history read for a copy
    logic wr_copy;  // write copied word to history and emit it
    logic flush;    // release the held result as the last of the word
  } cmd_t;

  typedef struct packed {
    ev_t  ev;         // what the current bit would complete
    logic last_bit;   // current bit is the final one of the word
    logic bits_zero;  // no bits left in the word
    logic copy_last;  // one copy word left
    logic push_ok;    // a new result can be taken
    logic pend_valid; // a result is held back
  } sts_t;

endpackage

// ===== rtl/lzs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_in_if
// Compressed word channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface lzs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/lzs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_out_if
// Decompressed result channel: valid/ready handshake with byte and flags.
// ----------------------------------------------------------------------------
interface lzs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       stream_end;
  logic       last;

  modport source (output valid, output out_byte, output has_byte,
                  output stream_end, output last, input ready);
  modport sink   (input valid, input out_byte, input has_byte,
                  input stream_end, input last, output ready);
endinterface

// ===== rtl/lzs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lzs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_dpath
// Bit decoder, history ring with fill tracking, copy counter, held result
// and output register of the LZS decompressor.
// ----------------------------------------------------------------------------
module lzs_dpath #(
  parameter int HISTORY_DEPTH = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lzs_pkg::cmd_t     cmd,
  output lzs_pkg::sts_t     sts,
  input  logic [7:0]        in_byte,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              has_byte,
  output logic              stream_end,
  output logic              last
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST   = AW'(HISTORY_DEPTH - 1);

  // decode state
  logic [lzs_pkg::BYTE_W-1:0]  sh_r;
  logic [lzs_pkg::CNT_W-1:0]   bits_left_r;
  lzs_pkg::phase_t             phase_r, phase_nxt;
  logic [lzs_pkg::FIELD_W-1:0] fld_r, fld_nxt;
  logic [lzs_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [lzs_pkg::OFF_W-1:0]   off_r, off_nxt;
  logic [lzs_pkg::FIELD_W-1:0] col_bits;
  logic [lzs_pkg::CNT_W-1:0]   col_cnt;
  lzs_pkg::ev_t                ev;
  logic [lzs_pkg::RUN_W-1:0]   run_len;

  // history
  logic [AW-1:0] wp_r;
  logic          wrapped_r;
  logic [AW:0]   diff, diff_wrap;
  logic [AW-1:0] src_addr;
  logic          src_ok, src_ok_r;
  logic [7:0]    ram_rdata, copy_byte;
  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic [lzs_pkg::RUN_W-1:0] copy_cnt_r;

  // held result and output register
  logic       pend_valid_r;
  logic [7:0] pend_byte_r;
  logic       pend_has_r, pend_end_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_has_r, out_end_r, out_last_r;
  logic       emit_new, push_out;
  logic [7:0] new_byte;
  logic       new_has, new_end;

  // --------------------------------------------------------------------------
  // one-bit token decode
  // --------------------------------------------------------------------------
  always_comb begin
    col_bits  = {fld_r[lzs_pkg::FIELD_W-2:0], sh_r[7]};
    col_cnt   = cnt_r + 4'd1;
    phase_nxt = phase_r;
    fld_nxt   = col_bits;
    cnt_nxt   = col_cnt;
    off_nxt   = off_r;
    ev        = lzs_pkg::EV_NONE;
    run_len   = '0;
    unique case (phase_r)
      lzs_pkg::PH_TOKEN: begin
        phase_nxt = sh_r[7] ? lzs_pkg::PH_KIND : lzs_pkg::PH_LIT;
        fld_nxt   = '0;
        cnt_nxt   = '0;
      end
      lzs_pkg::PH_KIND: begin
        phase_nxt = sh_r[7] ? lzs_pkg::PH_OFF7 : lzs_pkg::PH_OFF11;
        fld_nxt   = '0;
        cnt_nxt   = '0;
      end
      lzs_pkg::PH_LIT: begin
        if (col_cnt >= lzs_pkg::LIT_BITS) begin
          ev        = lzs_pkg::EV_LIT;
          phase_nxt = lzs_pkg::PH_TOKEN;
          fld_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      lzs_pkg::PH_OFF7: begin
        if (col_cnt >= lzs_pkg::OFF7_BITS) begin
          fld_nxt = '0;
          cnt_nxt = '0;
          if (col_bits[6:0] == 7'd0) begin
            // end marker
            ev        = lzs_pkg::EV_END;
            phase_nxt = lzs_pkg::PH_TOKEN;
          end else begin
            off_nxt   = {4'd0, col_bits[6:0]};
            phase_nxt = lzs_pkg::PH_LEN1;
          end
        end
      end
      lzs_pkg::PH_OFF11: begin
        if (col_cnt >= lzs_pkg::OFF11_BITS) begin
          off_nxt   = col_bits;
          phase_nxt = lzs_pkg::PH_LEN1;
          fld_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      lzs_pkg::PH_LEN1: begin
        if (col_cnt >= lzs_pkg::LEN_BITS) begin
          fld_nxt = '0;
          cnt_nxt = '0;
          if (col_bits[1:0] != lzs_pkg::LEN_ESC) begin
            ev        = lzs_pkg::EV_RUN;
            run_len   = lzs_pkg::RUN_W'(col_bits[1:0]) + lzs_pkg::LEN1_BASE;
            phase_nxt = lzs_pkg::PH_TOKEN;
          end else begin
            phase_nxt = lzs_pkg::PH_LEN2;
          end
        end
      end
      lzs_pkg::PH_LEN2: begin
        if (col_cnt >= lzs_pkg::LEN_BITS) begin
          fld_nxt = '0;
          cnt_nxt = '0;
          if (col_bits[1:0] != lzs_pkg::LEN_ESC) begin
            ev        = lzs_pkg::EV_RUN;
            run_len   = lzs_pkg::RUN_W'(col_bits[1:0]) + lzs_pkg::LEN2_BASE;
            phase_nxt = lzs_pkg::PH_TOKEN;
          end else begin
            phase_nxt = lzs_pkg::PH_NIBBLE;
          end
        end
      end
      lzs_pkg::PH_NIBBLE: begin
        if (col_cnt >= lzs_pkg::NIB_BITS) begin
          fld_nxt = '0;
          cnt_nxt = '0;
          ev      = lzs_pkg::EV_RUN;
          if (col_bits[3:0] == lzs_pkg::NIB_ESC) begin
            run_len   = lzs_pkg::NIB_RUN;
            phase_nxt = lzs_pkg::PH_NIBBLE;
          end else begin
            run_len   = lzs_pkg::RUN_W'(col_bits[3:0]) + lzs_pkg::NIB_BASE;
            phase_nxt = lzs_pkg::PH_TOKEN;
          end
        end
      end
      default: begin
        phase_nxt = lzs_pkg::PH_TOKEN;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // history ring: source address and fill tracking
  // --------------------------------------------------------------------------
  always_comb begin
    diff      = {1'b0, wp_r} - {1'b0, AW'(off_r)};
    diff_wrap = diff + DEPTH_EXT;
    src_addr  = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
    // entries never written since reset read as zero
    src_ok    = wrapped_r || (src_addr < wp_r);
  end

  assign copy_byte = src_ok_r ? ram_rdata : 8'd0;
  assign ram_we    = (cmd.step && (ev == lzs_pkg::EV_LIT)) || cmd.wr_copy;
  assign ram_wdata = cmd.wr_copy ? copy_byte : col_bits[7:0];

  lzs_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (src_addr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // result selection
  // --------------------------------------------------------------------------
  always_comb begin
    emit_new = cmd.wr_copy ||
               (cmd.step && ((ev == lzs_pkg::EV_LIT) || (ev == lzs_pkg::EV_END)));
    new_byte = 8'd0;
    new_has  = 1'b0;
    new_end  = 1'b0;
    if (cmd.wr_copy) begin
      new_byte = copy_byte;
      new_has  = 1'b1;
    end else if (ev == lzs_pkg::EV_LIT) begin
      new_byte = col_bits[7:0];
      new_has  = 1'b1;
    end else begin
      new_end  = 1'b1;
    end
    // a held result moves out when a newer one arrives or the word ends
    push_out = pend_valid_r && (emit_new || cmd.flush);
  end

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_left_r  <= '0;
      phase_r      <= lzs_pkg::PH_TOKEN;
      fld_r        <= '0;
      cnt_r        <= '0;
      off_r        <= '0;
      wp_r         <= '0;
      wrapped_r    <= 1'b0;
      copy_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        bits_left_r <= lzs_pkg::BYTE_BITS;
      end else if (cmd.step) begin
        bits_left_r <= bits_left_r - 4'd1;
      end
      if (cmd.step) begin
        phase_r <= phase_nxt;
        fld_r   <= fld_nxt;
        cnt_r   <= cnt_nxt;
        off_r   <= off_nxt;
      end
      if (cmd.step && (ev == lzs_pkg::EV_RUN)) begin
        copy_cnt_r <= run_len;
      end else if (cmd.wr_copy) begin
        copy_cnt_r <= copy_cnt_r - 5'd1;
      end
      if (ram_we) begin
        wp_r <= (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
        if (wp_r == WP_LAST) begin
          wrapped_r <= 1'b1;
        end
      end
      if (emit_new) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (push_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sh_r <= in_byte;
    end else if (cmd.step) begin
      sh_r <= {sh_r[6:0], 1'b0};
    end
    if (cmd.rd) begin
      src_ok_r <= src_ok;
    end
    if (emit_new) begin
      pend_byte_r <= new_byte;
      pend_has_r  <= new_has;
      pend_end_r  <= new_end;
    end
    if (push_out) begin
      out_byte_r <= pend_byte_r;
      out_has_r  <= pend_has_r;
      out_end_r  <= pend_end_r;
      out_last_r <= cmd.flush;
    end
  end

  always_comb begin
    sts.ev         = ev;
    sts.last_bit   = (bits_left_r == 4'd1);
    sts.bits_zero  = (bits_left_r == 4'd0);
    sts.copy_last  = (copy_cnt_r == 5'd1);
    sts.push_ok    = !pend_valid_r || !out_valid_r || out_ready;
    sts.pend_valid = pend_valid_r;
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign has_byte   = out_has_r;
  assign stream_end = out_end_r;
  assign last       = out_last_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (push_out && out_valid_r) |-> out_ready)
    else $error("held result pushed over an untaken output word");

  a_copy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_copy |-> (copy_cnt_r != 5'd0))
    else $error("copy word written with no run in progress");

  a_fill_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("history fill flag dropped");

endmodule

// ===== rtl/lzs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_ctrl
// Sequencer of the LZS decompressor: takes a word, walks its bits, runs the
// read/write loop of each match copy and releases the last result.
// ----------------------------------------------------------------------------
module lzs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lzs_pkg::sts_t sts,
  output lzs_pkg::cmd_t cmd
);

  lzs_pkg::ctl_state_t state_r, state_nxt;
  logic                emit_stall;

  assign emit_stall = (sts.ev inside {lzs_pkg::EV_LIT, lzs_pkg::EV_END}) && !sts.push_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lzs_pkg::ST_BIT;
        end
      end
      lzs_pkg::ST_BIT: begin
        if (!emit_stall) begin
          if (sts.ev == lzs_pkg::EV_END) begin
            state_nxt = lzs_pkg::ST_FLUSH;
          end else if (sts.ev == lzs_pkg::EV_RUN) begin
            state_nxt = lzs_pkg::ST_READ;
          end else if (sts.last_bit) begin
            state_nxt = lzs_pkg::ST_FLUSH;
          end
        end
      end
      lzs_pkg::ST_READ: begin
        state_nxt = lzs_pkg::ST_WRITE;
      end
      lzs_pkg::ST_WRITE: begin
        if (sts.push_ok) begin
          if (!sts.copy_last) begin
            state_nxt = lzs_pkg::ST_READ;
          end else if (sts.bits_zero) begin
            state_nxt = lzs_pkg::ST_FLUSH;
          end else begin
            state_nxt = lzs_pkg::ST_BIT;
          end
        end
      end
      lzs_pkg::ST_FLUSH: begin
        if (sts.push_ok) begin
          state_nxt = lzs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lzs_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lzs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lzs_pkg::ST_BIT: begin
        cmd.step = !emit_stall;
      end
      lzs_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      lzs_pkg::ST_WRITE: begin
        cmd.wr_copy = sts.push_ok;
      end
      lzs_pkg::ST_FLUSH: begin
        cmd.flush = sts.push_ok;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !sts.pend_valid)
    else $error("new word taken while a result of the previous one is held");

endmodule

// ===== rtl/lzs_stream_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_stream_decompressor
// LZS (Stac) decompressor: compressed bytes in, decompressed bytes out, with
// a history ring for match copies and an end-of-stream marker result.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                     Handshake
//  --------  ---  ------------------------------------------  -----------
//  in_chan   in   in_byte[7:0] (MSB first)                    valid/ready
//  out_chan  out  out_byte[7:0], has_byte, stream_end, last   valid/ready
//
//  Sequence: a word is accepted, its bits (up to 8) are decoded one by one,
//  each copied byte takes a history read, then a write and emit, and the
//  last result of the word is released; only then is a new word taken.
//  The history ring has a single read port with registered read data, so
//  each copied byte is read before it is written.
//  Reset: synchronous, active low; the ring needs no clearing pass, entries
//  not yet written since reset read as zero through a fill pointer.
//  Stalls: one result is held back until the next is known, so "last" can be
//  set; when the output stalls, decoding halts at its next result until taken.
// ----------------------------------------------------------------------------
module lzs_stream_decompressor #(
  parameter int HISTORY_DEPTH = 2048
) (
  input logic        clk,
  input logic        rst_n,
  lzs_in_if.sink     in_chan,
  lzs_out_if.source  out_chan
);

  lzs_pkg::cmd_t cmd;
  lzs_pkg::sts_t sts;

  // sequencer: word intake, bit walk, copy loop, final release
  lzs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // decoder, history ring and output register
  lzs_dpath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_chan.in_byte),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_byte   (out_chan.out_byte),
    .has_byte   (out_chan.has_byte),
    .stream_end (out_chan.stream_end),
    .last       (out_chan.last)
  );

endmodule

// ===== tb/lzs_stream_decompressor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzs_stream_decompressor_test
// Self-checking bench for the LZS stream decompressor. A short table of
// hand-packed compressed words runs first, then a long stream of randomly
// built tokens. Every accepted word is decoded by a bit-level model kept in
// the bench; each output word is matched in order against it, or against a
// typed result for some table rows. Both channels idle at random, and the
// output side holds off once for a long stretch so the block backs up its input.
// ----------------------------------------------------------------------------
module lzs_stream_decompressor_test;

  localparam int HIST_DEPTH   = 2048;
  localparam int MAX_RESULTS  = 40;
  localparam int RAND_WORDS   = 293;      // random words after the table
  localparam int MAX_WORDS    = 330;      // hard stop for the random stream
  localparam int WRAP_BYTES   = HIST_DEPTH + 256;
  localparam int HOLD_AFTER   = 300;      // output words before the long hold
  localparam int LONG_HOLD    = 1500;     // cycles with the output held off
  localparam int DRAIN_CYCLES = 100;      // wait for stray outputs after the last owed word
  localparam int CYCLE_LIMIT  = 1000000;

  // One output word of the decompressor.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       stream_end;
    logic       last;
  } result_t;

  // How a table row is checked.
  typedef enum {
    CHK_PREDICT,  // compare against the bench decoder
    CHK_QUIET,    // the word must produce no output
    CHK_SINGLE    // the word must produce exactly the typed output
  } chk_t;

  typedef struct {
    logic [7:0] data;
    chk_t       chk;
    result_t    typed;
  } vec_t;

  localparam result_t NO_WORD  = '0;
  localparam result_t END_MARK = '{8'h00, 1'b0, 1'b1, 1'b1};
  localparam result_t LIT_00   = '{8'h00, 1'b1, 1'b0, 1'b1};
  localparam result_t LIT_FF   = '{8'hFF, 1'b1, 1'b0, 1'b1};

  // Each group closes with an end marker so that the next group starts on a
  // word boundary; bits after a marker are junk that the block must drop.
  vec_t directed_tbl [17] = '{
    // end marker straight after reset, split across two words
    '{8'hC0, CHK_QUIET,   NO_WORD},
    '{8'h7F, CHK_SINGLE,  END_MARK},
    // literal 0x00, literal 0xFF, end marker, five junk bits
    '{8'h00, CHK_QUIET,   NO_WORD},
    '{8'h3F, CHK_SINGLE,  LIT_00},
    '{8'hF0, CHK_SINGLE,  LIT_FF},
    '{8'h1F, CHK_SINGLE,  END_MARK},
    // short offset 1 len 2, short offset 127 len 4, long offset 2047 len 5,
    // long offset 0 len 7, short offset 1 with nibbles 1111 0000 (len 23),
    // end marker, two junk bits
    '{8'hC0, CHK_PREDICT, NO_WORD},
    '{8'h9F, CHK_PREDICT, NO_WORD},
    '{8'hFA, CHK_PREDICT, NO_WORD},
    '{8'hFF, CHK_PREDICT, NO_WORD},
    '{8'hF9, CHK_PREDICT, NO_WORD},
    '{8'h00, CHK_PREDICT, NO_WORD},
    '{8'h0E, CHK_PREDICT, NO_WORD},
    '{8'hC0, CHK_PREDICT, NO_WORD},
    '{8'hFF, CHK_PREDICT, NO_WORD},
    '{8'h86, CHK_PREDICT, NO_WORD},
    '{8'h02, CHK_PREDICT, NO_WORD}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lzs_in_if  in_if ();
  lzs_out_if out_if ();

  lzs_stream_decompressor #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench decoder state: history ring, write pointer, the field being
  // collected and the offset of the match in progress.
  // --------------------------------------------------------------------------
  logic [7:0]                   hist_ring [HIST_DEPTH];
  logic [lzs_pkg::OFF_W-1:0]    wr_ptr;
  logic [lzs_pkg::FIELD_W-1:0]  field_bits;
  logic [lzs_pkg::CNT_W-1:0]    field_cnt;
  lzs_pkg::phase_t              phase;
  logic [lzs_pkg::OFF_W-1:0]    match_off;

  result_t word_results [$];  // outputs of the word being decoded
  result_t decoded_q [$];     // decoded outputs still owed by the block
  logic    bit_q [$];         // packed token bits not yet sent as words
  int      bytes_out;         // decompressed bytes produced so far
  int      mismatches;
  int      results_taken;
  logic    tx_burst;

  function automatic void clear_decoder();
    foreach (hist_ring[i]) hist_ring[i] = 8'h00;
    wr_ptr     = '0;
    field_bits = '0;
    field_cnt  = '0;
    phase      = lzs_pkg::PH_TOKEN;
    match_off  = '0;
    bytes_out  = 0;
  endfunction

  function automatic void open_field(lzs_pkg::phase_t next);
    phase      = next;
    field_bits = '0;
    field_cnt  = '0;
  endfunction

  // Shift one bit in; true once the field holds `need` bits.
  function automatic logic shift_in(logic b, logic [lzs_pkg::CNT_W-1:0] need);
    field_bits = {field_bits[lzs_pkg::FIELD_W-2:0], b};
    field_cnt  = field_cnt + 4'd1;
    return field_cnt >= need;
  endfunction

  function automatic void emit_result(logic [7:0] v, logic has, logic fin);
    if (word_results.size() < MAX_RESULTS)
      word_results.push_back('{v, has, fin, 1'b0});
  endfunction

  function automatic void store_byte(logic [7:0] v);
    hist_ring[wr_ptr] = v;
    wr_ptr = wr_ptr + 1'b1;
    bytes_out++;
    emit_result(v, 1'b1, 1'b0);
  endfunction

  // Copy n bytes from the ring; the source address follows the write pointer,
  // so short offsets repeat the bytes just written.
  function automatic void copy_run(int n);
    logic [lzs_pkg::OFF_W-1:0] src;
    for (int i = 0; i < n; i++) begin
      src = wr_ptr - match_off;
      store_byte(hist_ring[src]);
    end
  endfunction

  // Decode one compressed word, MSB first, into word_results.
  function automatic void decode_word(logic [7:0] w);
    logic b;
    logic stop;
    word_results.delete();
    for (int pos = 7; pos >= 0; pos--) begin
      b    = w[pos];
      stop = 1'b0;
      case (phase)
        lzs_pkg::PH_TOKEN: open_field(b ? lzs_pkg::PH_KIND : lzs_pkg::PH_LIT);
        lzs_pkg::PH_KIND:  open_field(b ? lzs_pkg::PH_OFF7 : lzs_pkg::PH_OFF11);
        lzs_pkg::PH_LIT: begin
          if (shift_in(b, lzs_pkg::LIT_BITS)) begin
            store_byte(field_bits[7:0]);
            open_field(lzs_pkg::PH_TOKEN);
          end
        end
        lzs_pkg::PH_OFF7: begin
          if (shift_in(b, lzs_pkg::OFF7_BITS)) begin
            if (field_bits == '0) begin
              // end marker: report it and drop the rest of the word
              emit_result(8'h00, 1'b0, 1'b1);
              open_field(lzs_pkg::PH_TOKEN);
              stop = 1'b1;
            end else begin
              match_off = {4'd0, field_bits[6:0]};
              open_field(lzs_pkg::PH_LEN1);
            end
          end
        end
        lzs_pkg::PH_OFF11: begin
          if (shift_in(b, lzs_pkg::OFF11_BITS)) begin
            match_off = field_bits;
            open_field(lzs_pkg::PH_LEN1);
          end
        end
        lzs_pkg::PH_LEN1: begin
          if (shift_in(b, lzs_pkg::LEN_BITS)) begin
            if (field_bits[1:0] != lzs_pkg::LEN_ESC) begin
              copy_run(int'(field_bits) + int'(lzs_pkg::LEN1_BASE));
              open_field(lzs_pkg::PH_TOKEN);
            end else begin
              open_field(lzs_pkg::PH_LEN2);
            end
          end
        end
        lzs_pkg::PH_LEN2: begin
          if (shift_in(b, lzs_pkg::LEN_BITS)) begin
            if (field_bits[1:0] != lzs_pkg::LEN_ESC) begin
              copy_run(int'(field_bits) + int'(lzs_pkg::LEN2_BASE));
              open_field(lzs_pkg::PH_TOKEN);
            end else begin
              open_field(lzs_pkg::PH_NIBBLE);
            end
          end
        end
        lzs_pkg::PH_NIBBLE: begin
          if (shift_in(b, lzs_pkg::NIB_BITS)) begin
            if (field_bits[3:0] == lzs_pkg::NIB_ESC) begin
              copy_run(int'(lzs_pkg::NIB_RUN));
              open_field(lzs_pkg::PH_NIBBLE);
            end else begin
              copy_run(int'(field_bits) + int'(lzs_pkg::NIB_BASE));
              open_field(lzs_pkg::PH_TOKEN);
            end
          end
        end
      endcase
      if (stop)
        break;
    end
    if (word_results.size() > 0)
      word_results[word_results.size()-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Token builder for the random stream: tokens go into bit_q MSB first and
  // leave as whole words. Long nibble runs dominate so that the ring wraps
  // within the planned number of words.
  // --------------------------------------------------------------------------
  function automatic void push_bits(logic [10:0] v, int n);
    for (int i = n - 1; i >= 0; i--)
      bit_q.push_back(v[i]);
  endfunction

  function automatic void build_token();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // literal
      push_bits(11'd0, 1);
      push_bits(11'($urandom_range(0, 255)), 8);
    end else if (pick < 93) begin
      // match: short or long offset, then a length code
      push_bits(11'd1, 1);
      if ($urandom_range(0, 1) == 1) begin
        push_bits(11'd1, 1);
        push_bits(11'($urandom_range(1, 127)), 7);
      end else begin
        push_bits(11'd0, 1);
        push_bits(11'($urandom_range(0, 2047)), 11);
      end
      if (pick < 45) begin
        push_bits(11'($urandom_range(0, 2)), 2);
      end else if (pick < 55) begin
        push_bits(11'(lzs_pkg::LEN_ESC), 2);
        push_bits(11'($urandom_range(0, 2)), 2);
      end else begin
        push_bits(11'({lzs_pkg::LEN_ESC, lzs_pkg::LEN_ESC}), 4);
        repeat ($urandom_range(0, 5)) push_bits(11'(lzs_pkg::NIB_ESC), 4);
        push_bits(11'($urandom_range(0, 14)), 4);
      end
    end else if (pick < 97) begin
      // end marker, then junk up to the word boundary
      push_bits(11'b11, 2);
      push_bits(11'd0, 7);
      while (bit_q.size() % 8 != 0)
        push_bits(11'($urandom_range(0, 1)), 1);
    end else begin
      // noise: a few stray bits that break the token framing
      repeat ($urandom_range(1, 7)) push_bits(11'($urandom_range(0, 1)), 1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side: wait a drawn number of cycles, offer the word, hold it until
  // accepted, then decode it in the bench. Valid stays high between words
  // when no gap is drawn.
  // --------------------------------------------------------------------------
  task automatic feed_word(input logic [7:0] w, input chk_t chk, input result_t typed);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0)
      tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.in_byte = w;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    // decode at the accepting edge, before any output can appear
    decode_word(w);
    case (chk)
      CHK_PREDICT: foreach (word_results[i]) decoded_q.push_back(word_results[i]);
      CHK_SINGLE:  decoded_q.push_back(typed);
      default:     ;
    endcase
    @(negedge clk);
  endtask

  // Match one output word against the oldest owed one.
  function automatic void check_result(result_t got);
    result_t want;
    if (decoded_q.size() == 0) begin
      mismatches++;
      $display("%0t: output word with none pending: byte %02h has %b end %b last %b",
               $time, got.out_byte, got.has_byte, got.stream_end, got.last);
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
        got.stream_end !== want.stream_end || got.last !== want.last) begin
      mismatches++;
      $display("%0t: mismatch: want byte %02h has %b end %b last %b,",
               $time, want.out_byte, want.has_byte, want.stream_end, want.last,
               " got byte %02h has %b end %b last %b",
               got.out_byte, got.has_byte, got.stream_end, got.last);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: draw a stall per word, with runs of no stalls, and one long
  // hold-off so the block fills up and pushes back on its input.
  // --------------------------------------------------------------------------
  initial begin : output_side
    int unsigned hold;
    logic        rx_burst;
    logic        held_off;
    result_t     got;
    rx_burst      = 1'b0;
    held_off      = 1'b0;
    results_taken = 0;
    out_if.ready  = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0)
        rx_burst = !rx_burst;
      hold = rx_burst ? 0 : $urandom_range(0, 12);
      if (!held_off && results_taken >= HOLD_AFTER) begin
        hold     = LONG_HOLD;
        held_off = 1'b1;
      end
      if (hold > 0) begin
        out_if.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got = '{out_if.out_byte, out_if.has_byte, out_if.stream_end, out_if.last};
      check_result(got);
      results_taken++;
      @(negedge clk);
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout with %0d output words pending", $time, decoded_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, table, random stream, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] w;
    int         n_rand;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    mismatches    = 0;
    tx_burst      = 1'b0;
    clear_decoder();

    // hold reset, then release it at a falling edge
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_tbl[i])
      feed_word(directed_tbl[i].data, directed_tbl[i].chk, directed_tbl[i].typed);

    // random tokens; stretch a little past the plan if the ring has not wrapped
    n_rand = 0;
    while ((n_rand < RAND_WORDS || bytes_out < WRAP_BYTES) && n_rand < MAX_WORDS) begin
      while (bit_q.size() < 8)
        build_token();
      w = '0;
      repeat (8) w = {w[6:0], bit_q.pop_front()};
      feed_word(w, CHK_PREDICT, NO_WORD);
      n_rand++;
    end
    in_if.valid = 1'b0;

    // wait for every owed word, then watch for strays
    while (decoded_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lzs_pkg.sv
rtl/lzs_in_if.sv
rtl/lzs_out_if.sv
rtl/lzs_ram.sv
rtl/lzs_dpath.sv
rtl/lzs_ctrl.sv
rtl/lzs_stream_decompressor.sv
tb/lzs_stream_decompressor_test.sv
